### hw/rtl/ate_pkg.sv
// shared types, constants and codes for the array table engine
package ate_pkg;

  localparam int DEPTH  = 64;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef logic [AW-1:0]        addr_t;
  typedef logic [CW-1:0]        cnt_t;
  typedef logic signed [31:0]   elem_t;
  typedef logic [QAW-1:0]       qptr_t;
  typedef logic [QCW-1:0]       qcnt_t;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_SEARCH = 3'd4,
    CMD_DUMP   = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ES_IDLE,
    ES_SHIFT_UP,
    ES_FIND,
    ES_SHIFT_DN,
    ES_SCAN,
    ES_FIN
  } eng_state_t;

  typedef struct packed {
    cmd_t  cmd;
    cnt_t  pos;
    elem_t val;
  } req_t;

endpackage

### hw/rtl/array_table_engine_top.sv
// array table engine: single-result commands pass through the request queue and the result register
// insert walks count-pos entries, delete/search/dump walk up to count entries, one per cycle unless the output stalls
// other commands leave the engine once the result register is free; a 2-entry queue sits ahead
// synchronous active-low reset empties the queue, zeroes the count and drops pending results
// element memory is not cleared by reset; entries are read only below the count
module array_table_engine_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [2:0]   in_command,
  input  logic [6:0]   in_position,
  input  logic signed [31:0] in_value,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [2:0]   out_status,
  output logic [5:0]   out_index,
  output logic signed [31:0] out_element,
  output logic         out_last
);

  logic          q_valid;
  logic          q_pop;
  ate_pkg::req_t q_req;

  ate_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_command  (in_command),
    .in_position (in_position),
    .in_value    (in_value),
    .q_valid     (q_valid),
    .q_req       (q_req),
    .q_pop       (q_pop)
  );

  ate_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_req       (q_req),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status),
    .out_index   (out_index),
    .out_element (out_element),
    .out_last    (out_last)
  );

endmodule

### hw/rtl/ate_front.sv
// request intake: drops unused command codes and queues the rest for the engine
module ate_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [2:0]      in_command,
  input  ate_pkg::cnt_t   in_position,
  input  ate_pkg::elem_t  in_value,
  output logic            q_valid,
  output ate_pkg::req_t   q_req,
  input  logic            q_pop
);

  ate_pkg::req_t  q_mem_r [ate_pkg::QDEPTH];
  ate_pkg::qptr_t wr_ptr_r, wr_ptr_nxt;
  ate_pkg::qptr_t rd_ptr_r, rd_ptr_nxt;
  ate_pkg::qcnt_t fill_r, fill_nxt;
  logic           known;
  logic           push;

  assign in_ready = (fill_r != ate_pkg::qcnt_t'(ate_pkg::QDEPTH));
  assign known    = (in_command <= ate_pkg::CMD_DUMP);
  // codes beyond dump are taken and dropped without a result
  assign push     = in_valid && in_ready && known;
  assign q_valid  = (fill_r != '0);
  assign q_req    = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + ate_pkg::qptr_t'(1);
    end
    if (q_pop) begin
      rd_ptr_nxt = rd_ptr_r + ate_pkg::qptr_t'(1);
    end
    priority if (push && !q_pop) begin
      fill_nxt = fill_r + ate_pkg::qcnt_t'(1);
    end else if (!push && q_pop) begin
      fill_nxt = fill_r - ate_pkg::qcnt_t'(1);
    end else begin
      fill_nxt = fill_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= '{cmd: ate_pkg::cmd_t'(in_command), pos: in_position,
                             val: in_value};
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= ate_pkg::qcnt_t'(ate_pkg::QDEPTH))
    else $error("request queue fill above its depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("engine popped an empty request queue");

endmodule

### hw/rtl/ate_engine.sv
// back end: element memory, count and the sequencer that walks, shifts and emits results
module ate_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  ate_pkg::req_t    q_req,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       out_status,
  output ate_pkg::addr_t   out_index,
  output ate_pkg::elem_t   out_element,
  output logic             out_last
);

  ate_pkg::elem_t      mem [ate_pkg::DEPTH];
  ate_pkg::elem_t      rd_data_r;

  ate_pkg::eng_state_t state_r, state_nxt;
  ate_pkg::cnt_t       count_r, count_nxt;
  ate_pkg::addr_t      ptr_r, ptr_nxt;
  logic                rd_done_r, rd_done_nxt;
  logic                p_valid_r, p_valid_nxt;
  ate_pkg::addr_t      p_idx_r, p_idx_nxt;
  logic                h_valid_r, h_valid_nxt;
  ate_pkg::addr_t      h_idx_r, h_idx_nxt;
  ate_pkg::cmd_t       cmd_r;
  ate_pkg::addr_t      pos_r;
  ate_pkg::elem_t      val_r;

  logic                out_valid_r;
  ate_pkg::status_t    out_status_r;
  ate_pkg::addr_t      out_index_r;
  ate_pkg::elem_t      out_element_r;
  logic                out_last_r;

  logic                out_free;
  logic                match;
  logic                p_last;
  logic                ptr_last;
  logic                latch;
  logic                we, re;
  ate_pkg::addr_t      wa, ra;
  ate_pkg::elem_t      wd;
  logic                o_load;
  ate_pkg::status_t    o_status;
  ate_pkg::addr_t      o_index;
  ate_pkg::elem_t      o_elem;
  logic                o_last;
  logic                go_idle, go_up, go_find, go_dn, go_scan, go_fin;

  assign out_free = !out_valid_r || out_ready;
  assign match    = (rd_data_r == val_r);
  assign p_last   = (ate_pkg::cnt_t'(p_idx_r) + ate_pkg::cnt_t'(1) == count_r);
  assign ptr_last = (ate_pkg::cnt_t'(ptr_r) + ate_pkg::cnt_t'(1) == count_r);

  // next state
  always_comb begin
    priority if (go_idle) begin
      state_nxt = ate_pkg::ES_IDLE;
    end else if (go_up) begin
      state_nxt = ate_pkg::ES_SHIFT_UP;
    end else if (go_find) begin
      state_nxt = ate_pkg::ES_FIND;
    end else if (go_dn) begin
      state_nxt = ate_pkg::ES_SHIFT_DN;
    end else if (go_scan) begin
      state_nxt = ate_pkg::ES_SCAN;
    end else if (go_fin) begin
      state_nxt = ate_pkg::ES_FIN;
    end else begin
      state_nxt = state_r;
    end
  end

  // datapath control and result generation
  always_comb begin
    logic             single;
    logic             wr_new;
    logic             issue;
    logic             p_adv;
    ate_pkg::status_t st;
    single      = 1'b0;
    wr_new      = 1'b0;
    issue       = 1'b0;
    p_adv       = 1'b0;
    st          = ate_pkg::ST_OK;
    q_pop       = 1'b0;
    latch       = 1'b0;
    we          = 1'b0;
    wa          = p_idx_r;
    wd          = rd_data_r;
    re          = 1'b0;
    ra          = ptr_r;
    o_load      = 1'b0;
    o_index     = '0;
    o_elem      = '0;
    o_last      = 1'b1;
    count_nxt   = count_r;
    ptr_nxt     = ptr_r;
    rd_done_nxt = rd_done_r;
    p_valid_nxt = p_valid_r;
    p_idx_nxt   = p_idx_r;
    h_valid_nxt = h_valid_r;
    h_idx_nxt   = h_idx_r;
    go_idle     = 1'b0;
    go_up       = 1'b0;
    go_find     = 1'b0;
    go_dn       = 1'b0;
    go_scan     = 1'b0;
    go_fin      = 1'b0;

    unique case (state_r)
      ate_pkg::ES_IDLE: begin
        if (q_valid) begin
          unique case (q_req.cmd)
            ate_pkg::CMD_CLEAR: begin
              single = 1'b1;
            end
            ate_pkg::CMD_APPEND: begin
              single = 1'b1;
              if (count_r == ate_pkg::cnt_t'(ate_pkg::DEPTH)) begin
                st = ate_pkg::ST_FULL;
              end else begin
                wr_new = 1'b1;
              end
            end
            ate_pkg::CMD_INSERT: begin
              priority if (count_r == '0) begin
                single = 1'b1;
                st     = ate_pkg::ST_EMPTY;
              end else if (q_req.pos > count_r) begin
                single = 1'b1;
                st     = ate_pkg::ST_BADPOS;
              end else if (count_r == ate_pkg::cnt_t'(ate_pkg::DEPTH)) begin
                single = 1'b1;
                st     = ate_pkg::ST_FULL;
              end else if (q_req.pos == count_r) begin
                // insert at the end needs no shift
                single = 1'b1;
                wr_new = 1'b1;
              end else begin
                go_up   = 1'b1;
                ptr_nxt = ate_pkg::addr_t'(count_r - ate_pkg::cnt_t'(1));
              end
            end
            ate_pkg::CMD_DELETE, ate_pkg::CMD_SEARCH, ate_pkg::CMD_DUMP: begin
              if (count_r == '0) begin
                single = 1'b1;
                st     = ate_pkg::ST_EMPTY;
              end else begin
                go_find = (q_req.cmd == ate_pkg::CMD_DELETE);
                go_scan = (q_req.cmd != ate_pkg::CMD_DELETE);
                ptr_nxt = '0;
              end
            end
            default: begin
            end
          endcase
          if (go_up || go_find || go_scan) begin
            q_pop       = 1'b1;
            latch       = 1'b1;
            rd_done_nxt = 1'b0;
            p_valid_nxt = 1'b0;
            h_valid_nxt = 1'b0;
          end else if (single && out_free) begin
            q_pop  = 1'b1;
            o_load = 1'b1;
            if (wr_new) begin
              we        = 1'b1;
              wa        = ate_pkg::addr_t'(count_r);
              wd        = q_req.val;
              count_nxt = count_r + ate_pkg::cnt_t'(1);
            end
            if (q_req.cmd == ate_pkg::CMD_CLEAR) begin
              count_nxt = '0;
            end
          end
        end
      end

      ate_pkg::ES_SHIFT_UP: begin
        // read entry i, write it to i+1 next cycle, walking down to the position
        if (p_valid_r) begin
          we = 1'b1;
          wa = p_idx_r + ate_pkg::addr_t'(1);
          wd = rd_data_r;
        end
        if (!rd_done_r) begin
          issue = 1'b1;
          if (ptr_r == pos_r) begin
            rd_done_nxt = 1'b1;
          end else begin
            ptr_nxt = ptr_r - ate_pkg::addr_t'(1);
          end
        end else if (!p_valid_r && out_free) begin
          we        = 1'b1;
          wa        = pos_r;
          wd        = val_r;
          count_nxt = count_r + ate_pkg::cnt_t'(1);
          o_load    = 1'b1;
          go_idle   = 1'b1;
        end
        p_valid_nxt = issue;
      end

      ate_pkg::ES_FIND: begin
        priority if (p_valid_r && match) begin
          go_dn       = 1'b1;
          p_valid_nxt = 1'b0;
          if (p_last) begin
            rd_done_nxt = 1'b1;
          end else begin
            ptr_nxt     = p_idx_r + ate_pkg::addr_t'(1);
            rd_done_nxt = 1'b0;
          end
        end else if (p_valid_r && p_last) begin
          if (out_free) begin
            o_load      = 1'b1;
            st          = ate_pkg::ST_NOTFOUND;
            p_valid_nxt = 1'b0;
            go_idle     = 1'b1;
          end
        end else begin
          if (!rd_done_r) begin
            issue = 1'b1;
            if (ptr_last) begin
              rd_done_nxt = 1'b1;
            end else begin
              ptr_nxt = ptr_r + ate_pkg::addr_t'(1);
            end
          end
          p_valid_nxt = issue;
        end
      end

      ate_pkg::ES_SHIFT_DN: begin
        // read entry i, write it to i-1 next cycle, walking up to the top
        if (p_valid_r) begin
          we = 1'b1;
          wa = p_idx_r - ate_pkg::addr_t'(1);
          wd = rd_data_r;
        end
        if (!rd_done_r) begin
          issue = 1'b1;
          if (ptr_last) begin
            rd_done_nxt = 1'b1;
          end else begin
            ptr_nxt = ptr_r + ate_pkg::addr_t'(1);
          end
        end else if (!p_valid_r && out_free) begin
          count_nxt = count_r - ate_pkg::cnt_t'(1);
          o_load    = 1'b1;
          go_idle   = 1'b1;
        end
        p_valid_nxt = issue;
      end

      ate_pkg::ES_SCAN: begin
        if (p_valid_r) begin
          priority if (cmd_r == ate_pkg::CMD_DUMP) begin
            if (out_free) begin
              o_load  = 1'b1;
              o_index = p_idx_r;
              o_elem  = rd_data_r;
              o_last  = p_last;
              p_adv   = 1'b1;
            end
          end else if (match) begin
            // a match is held back until the next one shows whether it is the last
            if (!h_valid_r) begin
              h_valid_nxt = 1'b1;
              h_idx_nxt   = p_idx_r;
              p_adv       = 1'b1;
            end else if (out_free) begin
              o_load    = 1'b1;
              o_index   = h_idx_r;
              o_elem    = val_r;
              o_last    = 1'b0;
              h_idx_nxt = p_idx_r;
              p_adv     = 1'b1;
            end
          end else begin
            p_adv = 1'b1;
          end
        end
        if (!rd_done_r && (!p_valid_r || p_adv)) begin
          issue = 1'b1;
          if (ptr_last) begin
            rd_done_nxt = 1'b1;
          end else begin
            ptr_nxt = ptr_r + ate_pkg::addr_t'(1);
          end
        end
        if (!p_valid_r || p_adv) begin
          p_valid_nxt = issue;
        end
        if (p_adv && p_last) begin
          go_idle = (cmd_r == ate_pkg::CMD_DUMP);
          go_fin  = (cmd_r != ate_pkg::CMD_DUMP);
        end
      end

      ate_pkg::ES_FIN: begin
        if (out_free) begin
          o_load = 1'b1;
          if (h_valid_r) begin
            o_index = h_idx_r;
            o_elem  = val_r;
          end else begin
            st = ate_pkg::ST_NOTFOUND;
          end
          h_valid_nxt = 1'b0;
          go_idle     = 1'b1;
        end
      end

      default: begin
        go_idle = 1'b1;
      end
    endcase

    if (issue) begin
      re        = 1'b1;
      ra        = ptr_r;
      p_idx_nxt = ptr_r;
    end
    o_status = st;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data_r <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ate_pkg::ES_IDLE;
      count_r     <= '0;
      rd_done_r   <= 1'b0;
      p_valid_r   <= 1'b0;
      h_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_done_r   <= rd_done_nxt;
      p_valid_r   <= p_valid_nxt;
      h_valid_r   <= h_valid_nxt;
      if (o_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r   <= ptr_nxt;
    p_idx_r <= p_idx_nxt;
    h_idx_r <= h_idx_nxt;
    if (latch) begin
      cmd_r <= q_req.cmd;
      pos_r <= ate_pkg::addr_t'(q_req.pos);
      val_r <= q_req.val;
    end
    if (o_load) begin
      out_status_r  <= o_status;
      out_index_r   <= o_index;
      out_element_r <= o_elem;
      out_last_r    <= o_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_index   = out_index_r;
  assign out_element = out_element_r;
  assign out_last    = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ate_pkg::cnt_t'(ate_pkg::DEPTH))
    else $error("element count above depth");

  a_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ate_pkg::ES_IDLE) |-> !p_valid_r)
    else $error("read data pending while idle");

  a_held_match: assert property (@(posedge clk) disable iff (!rst_n)
    h_valid_r |-> (state_r == ate_pkg::ES_SCAN || state_r == ate_pkg::ES_FIN))
    else $error("held search match outside a search");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    o_load |-> out_free)
    else $error("result register overwritten before it was taken");

endmodule
